@@ sv/i2crm_pkg.sv @@
`timescale 1ns / 1ps

package i2crm_pkg;

    localparam int PHASE_W = 4;
    localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;
    localparam logic [7:0] READ_BIT = 8'h01;
    localparam logic [7:0] MSB_MASK = 8'h80;

    // transaction codes carried on func
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_BURST = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NACK  = 2'd1;
    localparam logic [1:0] STATUS_BUSY  = 2'd2;
    localparam logic [1:0] STATUS_ERROR = 2'd3;

    typedef enum logic [3:0] {
        OP_END,
        OP_START,
        OP_SEND_ADDR,
        OP_SEND_REG,
        OP_SEND_VAL,
        OP_SEND_ADDR_RD,
        OP_RECV,
        OP_ACKX,
        OP_STOP,
        OP_WAIT
    } op_t;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] device_addr;
        logic [7:0] reg_index;
        logic [7:0] write_value;
        logic [7:0] burst_count;
        logic       sda_level;
    } in_t;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       last_byte;
        logic [1:0] bus_status;
    } out_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [PHASE_W-1:0] phase;
        logic [7:0]         timer;
        logic [3:0]         bit_cnt;
        logic               bit_half;
        logic [7:0]         shift;
        logic [7:0]         bytes_left;
        logic [7:0]         addr;
        logic [7:0]         reg_idx;
        logic [7:0]         value;
        logic [1:0]         status;
        logic               scl;
        logic               sda;
    } core_state_t;

    localparam core_state_t CORE_RESET = '{
        kind: FUNC_TICK, phase: '0, timer: '0, bit_cnt: '0, bit_half: 1'b0,
        shift: '0, bytes_left: '0, addr: '0, reg_idx: '0, value: '0,
        status: STATUS_OK, scl: 1'b1, sda: 1'b1
    };

    // sequence of bus segments for each transaction kind
    function automatic op_t prog_op(input logic [1:0] kind, input logic [PHASE_W-1:0] ph);
        op_t op;
        op = OP_END;
        case (kind)
            FUNC_WRITE:
            begin
                case (ph)
                    4'd0: op = OP_START;
                    4'd1: op = OP_SEND_ADDR;
                    4'd2: op = OP_SEND_REG;
                    4'd3: op = OP_SEND_VAL;
                    4'd4: op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            FUNC_READ:
            begin
                case (ph)
                    4'd0: op = OP_START;
                    4'd1: op = OP_SEND_ADDR;
                    4'd2: op = OP_SEND_REG;
                    4'd3: op = OP_STOP;
                    4'd4: op = OP_WAIT;
                    4'd5: op = OP_WAIT;
                    4'd6: op = OP_START;
                    4'd7: op = OP_SEND_ADDR_RD;
                    4'd8: op = OP_RECV;
                    4'd9: op = OP_ACKX;
                    4'd10: op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            FUNC_BURST:
            begin
                case (ph)
                    4'd0: op = OP_START;
                    4'd1: op = OP_SEND_ADDR;
                    4'd2: op = OP_SEND_REG;
                    4'd3: op = OP_WAIT;
                    4'd4: op = OP_START;
                    4'd5: op = OP_SEND_ADDR_RD;
                    4'd6: op = OP_RECV;
                    4'd7: op = OP_ACKX;
                    4'd8: op = OP_STOP;
                    default: op = OP_END;
                endcase
            end
            default: op = OP_END;
        endcase
        return op;
    endfunction

endpackage

@@ sv/i2crm_core.sv @@
`timescale 1ns / 1ps

module i2crm_core
    import i2crm_pkg::*;
(
    input  core_state_t state_cur,
    input  logic [7:0]  phase_ticks,
    input  in_t         in_data,
    output core_state_t state_nxt,
    output out_t        result
);

    function automatic core_state_t enter_seg(input core_state_t s_in);
        core_state_t s;
        op_t         op;
        s = s_in;
        op = prog_op(s.kind, s.phase);
        s.bit_cnt = '0;
        s.bit_half = 1'b0;
        case (op)
            OP_SEND_ADDR:    s.shift = s.addr;
            OP_SEND_REG:     s.shift = s.reg_idx;
            OP_SEND_VAL:     s.shift = s.value;
            OP_SEND_ADDR_RD: s.shift = s.addr | READ_BIT;
            OP_RECV:         s.shift = '0;
            OP_END:
            begin
                s.kind = FUNC_TICK;
                s.phase = '0;
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic core_state_t finish_seg(input core_state_t s_in);
        core_state_t s;
        s = s_in;
        s.phase = s.phase + 1'b1;
        return enter_seg(s);
    endfunction

    function automatic logic [1:0] raise(input logic [1:0] cur, input logic [1:0] code);
        return (code > cur) ? code : cur;
    endfunction

    core_state_t s;
    op_t         op;
    logic [7:0]  eff;
    logic        sending;
    logic        busy;
    logic        rd_valid;
    logic [7:0]  rd_byte;
    logic        rd_last;
    logic        sda;

    always_comb
    begin
        s = state_cur;
        sda = in_data.sda_level;
        busy = 1'b0;
        rd_valid = 1'b0;
        rd_byte = '0;
        rd_last = 1'b0;
        eff = (phase_ticks == '0) ? 8'd1 : phase_ticks;

        if (s.kind == FUNC_TICK && in_data.func != FUNC_TICK)
        begin
            s.addr = in_data.device_addr;
            s.reg_idx = in_data.reg_index;
            s.value = in_data.write_value;
            s.kind = in_data.func;
            s.status = STATUS_OK;
            if (in_data.func == FUNC_BURST && in_data.burst_count != '0)
                s.bytes_left = in_data.burst_count;
            else
                s.bytes_left = 8'd1;
            s.timer = '0;
            s.phase = '0;
            s = enter_seg(s);
        end

        op = prog_op(s.kind, s.phase);
        sending = (op == OP_SEND_ADDR) || (op == OP_SEND_REG) ||
                  (op == OP_SEND_VAL) || (op == OP_SEND_ADDR_RD);

        if (s.kind != FUNC_TICK)
        begin
            busy = 1'b1;
            // drive levels for this phase
            case (op)
                OP_START:
                begin
                    if (s.bit_cnt == 4'd0)
                        s.sda = 1'b1;
                    else if (s.bit_cnt == 4'd1)
                    begin
                        s.scl = 1'b1;
                        s.sda = 1'b1;
                    end
                    else if (s.bit_cnt == 4'd2)
                    begin
                        s.scl = 1'b1;
                        s.sda = 1'b0;
                    end
                    else
                    begin
                        s.scl = 1'b0;
                        s.sda = 1'b0;
                    end
                end
                OP_RECV:
                begin
                    s.sda = 1'b1;
                    s.scl = ~s.bit_half;
                end
                OP_ACKX:
                begin
                    if (s.bit_cnt == 4'd0)
                    begin
                        s.sda = (s.bytes_left > 8'd1) ? 1'b0 : 1'b1;
                        s.scl = 1'b0;
                    end
                    else if (s.bit_cnt == 4'd1)
                        s.scl = 1'b1;
                    else
                        s.scl = 1'b0;
                end
                OP_STOP:
                begin
                    if (s.bit_cnt == 4'd0)
                        s.sda = 1'b0;
                    else if (s.bit_cnt == 4'd1)
                        s.scl = 1'b1;
                    else
                        s.sda = 1'b1;
                end
                default:
                begin
                    if (sending)
                    begin
                        s.scl = s.bit_half;
                        s.sda = (s.bit_cnt < 4'd8) ? ((s.shift & MSB_MASK) != '0) : 1'b1;
                    end
                end
            endcase

            s.timer = s.timer + 1'b1;
            if (s.timer >= eff)
            begin
                s.timer = '0;
                case (op)
                    OP_START:
                    begin
                        if (s.bit_cnt == 4'd1 && !sda)
                        begin
                            // line held low by another master: skip rest of start
                            s.status = raise(s.status, STATUS_BUSY);
                            s = finish_seg(s);
                        end
                        else if (s.bit_cnt >= 4'd3)
                        begin
                            if (sda)
                                s.status = raise(s.status, STATUS_ERROR);
                            s = finish_seg(s);
                        end
                        else
                            s.bit_cnt = s.bit_cnt + 1'b1;
                    end
                    OP_RECV:
                    begin
                        if (!s.bit_half)
                        begin
                            s.shift = {s.shift[6:0], sda};
                            if (s.bit_cnt >= 4'd7)
                            begin
                                rd_valid = 1'b1;
                                rd_byte = s.shift;
                                rd_last = (s.bytes_left <= 8'd1);
                            end
                            s.bit_half = 1'b1;
                        end
                        else if (s.bit_cnt >= 4'd7)
                            s = finish_seg(s);
                        else
                        begin
                            s.bit_cnt = s.bit_cnt + 1'b1;
                            s.bit_half = 1'b0;
                        end
                    end
                    OP_ACKX:
                    begin
                        if (s.bit_cnt < 4'd2)
                            s.bit_cnt = s.bit_cnt + 1'b1;
                        else if (s.bytes_left > 8'd1)
                        begin
                            // step back to receive the next byte of the burst
                            s.sda = 1'b1;
                            s.bytes_left = s.bytes_left - 1'b1;
                            s.phase = s.phase - 1'b1;
                            s = enter_seg(s);
                        end
                        else
                            s = finish_seg(s);
                    end
                    OP_STOP:
                    begin
                        if (s.bit_cnt < 4'd2)
                            s.bit_cnt = s.bit_cnt + 1'b1;
                        else
                            s = finish_seg(s);
                    end
                    default:
                    begin
                        if (sending)
                        begin
                            if (!s.bit_half)
                                s.bit_half = 1'b1;
                            else if (s.bit_cnt < 4'd8)
                            begin
                                s.shift = {s.shift[6:0], 1'b0};
                                s.bit_cnt = s.bit_cnt + 1'b1;
                                s.bit_half = 1'b0;
                            end
                            else
                            begin
                                if (sda)
                                    s.status = raise(s.status, STATUS_NACK);
                                s.scl = 1'b0;
                                s.sda = 1'b1;
                                s = finish_seg(s);
                            end
                        end
                        else
                            s = finish_seg(s);
                    end
                endcase
            end
        end

        state_nxt = s;
        result.scl_drive = s.scl;
        result.sda_drive = s.sda;
        result.busy_res = busy;
        result.read_valid = rd_valid;
        result.read_byte = rd_byte;
        result.last_byte = rd_valid && rd_last;
        result.bus_status = s.status;
    end

endmodule

@@ sv/i2c_register_master_top.sv @@
`timescale 1ns / 1ps

// I2C register master stepped one tick per input beat. Each accepted beat advances the bus
// sequencer by one tick (func 1, 2 or 3 starts a register write, single read or burst read
// when idle) and yields exactly one result beat, ready in the output register on the next
// clock. A beat is accepted every clock while the output register is empty or being taken,
// so the sustained rate is one beat per cycle, as long as the output is not stalled.
// phase_ticks (cfg_wr_en/cfg_wr_data) sets how many ticks each bus phase is held; write it
// only while no transaction runs.

module i2c_register_master_top
    import i2crm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_t        in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_t       out_data,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    core_state_t state_reg;
    core_state_t state_next;
    out_t        result;
    out_t        out_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  phase_ticks_reg;
    logic        accept;

    assign in_stall = out_valid_reg && out_stall;
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

    i2crm_core u_core (
        .state_cur   (state_reg),
        .phase_ticks (phase_ticks_reg),
        .in_data     (in_data),
        .state_nxt   (state_next),
        .result      (result)
    );

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_RESET;
            out_valid_reg <= 1'b0;
            phase_ticks_reg <= PHASE_TICKS_RESET;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                phase_ticks_reg <= cfg_wr_data;
        end
    end

    // hold the result while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= result;
    end

endmodule

@@ sv/i2crm_checker.sv @@
`timescale 1ns / 1ps

module i2crm_checker
    import i2crm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input out_t       out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result beat changed");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with free output register");

    a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted beat gave no result");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.read_valid |->
            out_data.read_byte == 8'd0 && !out_data.last_byte)
        else $error("read fields set without a received byte");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.read_valid |-> out_data.busy_res)
        else $error("byte received while not busy");

endmodule

bind i2c_register_master_top i2crm_checker u_i2crm_checker (.*);
